// File: rtl/core/bdae_pkg.sv
`timescale 1ns / 1ps
package bdae_pkg;

  localparam int SqW  = 32;
  localparam int RootW = 16;
  localparam int RemW  = 17;
  localparam int CorW  = 29;
  localparam int AngW  = 23;
  localparam int CorSteps = 16;
  localparam int NumW = 39;
  localparam int DenW = 28;

  typedef struct packed {
    logic [9:0]  pos_x;
    logic [9:0]  pos_y;
    logic [11:0] radius_q4;
  } in_t;

  typedef struct packed {
    logic signed [15:0] distance_q4;
    logic [13:0]        angle_centideg;
    logic               right_side;
    logic [2:0]         band_index;
    logic               zero_divisor;
  } out_t;

  typedef enum logic [3:0] {
    REG_ROW_ONE   = 4'd0,
    REG_ROW_TWO   = 4'd1,
    REG_ROW_THREE = 4'd2,
    REG_ROW_FOUR  = 4'd3,
    REG_PIVOT_X   = 4'd4,
    REG_PIVOT_Y   = 4'd5,
    REG_CENTRE_X  = 4'd6,
    REG_CENTRE_Y  = 4'd7
  } reg_idx_t;

  localparam logic [9:0] RST_ROW_ONE   = 10'd77;
  localparam logic [9:0] RST_ROW_TWO   = 10'd45;
  localparam logic [9:0] RST_ROW_THREE = 10'd29;
  localparam logic [9:0] RST_ROW_FOUR  = 10'd17;
  localparam logic [9:0] RST_PIVOT_X   = 10'd160;
  localparam logic [9:0] RST_PIVOT_Y   = 10'd490;
  localparam logic [9:0] RST_CENTRE_X  = 10'd160;
  localparam logic [9:0] RST_CENTRE_Y  = 10'd120;

  typedef struct packed {
    logic [RemW-1:0]  rem;
    logic [RootW-1:0] root;
    logic [SqW-1:0]   op;
  } sqrt_t;

  typedef struct packed {
    logic signed [CorW-1:0] x;
    logic signed [CorW-1:0] y;
    logic signed [AngW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [DenW-1:0] rem;
    logic [NumW-1:0] num;
    logic [NumW-1:0] q;
    logic [DenW-1:0] den;
  } div_t;

  function automatic logic [12:0] near_slope(input logic [2:0] b);
    case (b)
      3'd0:    near_slope = 13'd3461;
      3'd1:    near_slope = 13'd3032;
      3'd2:    near_slope = 13'd3281;
      3'd3:    near_slope = 13'd4418;
      default: near_slope = 13'd2550;
    endcase
  endfunction

  function automatic logic [14:0] near_offset(input logic [2:0] b);
    case (b)
      3'd0:    near_offset = 15'd23062;
      3'd1:    near_offset = 15'd12204;
      3'd2:    near_offset = 15'd8435;
      3'd3:    near_offset = 15'd5745;
      default: near_offset = 15'd5152;
    endcase
  endfunction

  function automatic logic [12:0] far_slope(input logic [2:0] b);
    case (b)
      3'd0:    far_slope = 13'd3032;
      3'd1:    far_slope = 13'd3281;
      3'd2:    far_slope = 13'd4418;
      3'd3:    far_slope = 13'd2550;
      default: far_slope = 13'd1525;
    endcase
  endfunction

  function automatic logic [14:0] far_offset(input logic [2:0] b);
    case (b)
      3'd0:    far_offset = 15'd12204;
      3'd1:    far_offset = 15'd8435;
      3'd2:    far_offset = 15'd5745;
      3'd3:    far_offset = 15'd5152;
      default: far_offset = 15'd4791;
    endcase
  endfunction

  function automatic logic [20:0] step_angle(input int i);
    case (i)
      0:       step_angle = 21'd1152000;
      1:       step_angle = 21'd680065;
      2:       step_angle = 21'd359328;
      3:       step_angle = 21'd182400;
      4:       step_angle = 21'd91554;
      5:       step_angle = 21'd45822;
      6:       step_angle = 21'd22916;
      7:       step_angle = 21'd11459;
      8:       step_angle = 21'd5730;
      9:       step_angle = 21'd2865;
      10:      step_angle = 21'd1432;
      11:      step_angle = 21'd716;
      12:      step_angle = 21'd358;
      13:      step_angle = 21'd179;
      14:      step_angle = 21'd90;
      default: step_angle = 21'd45;
    endcase
  endfunction

endpackage

// File: rtl/core/bdae_sqrt_cell.sv
`timescale 1ns / 1ps
module bdae_sqrt_cell (
  input  logic            clk,
  input  logic            en,
  input  bdae_pkg::sqrt_t d_in,
  output bdae_pkg::sqrt_t d_out
);
  import bdae_pkg::*;

  logic [RemW+1:0] rem_sh;
  logic [RemW+1:0] trial;
  sqrt_t           d_nxt;

  always_comb begin
    rem_sh = {d_in.rem, d_in.op[SqW-1 -: 2]};
    trial  = {1'b0, d_in.root, 2'b01};
    d_nxt.op = {d_in.op[SqW-3:0], 2'b00};
    if (rem_sh >= trial) begin
      d_nxt.rem  = RemW'(rem_sh - trial);
      d_nxt.root = {d_in.root[RootW-2:0], 1'b1};
    end else begin
      d_nxt.rem  = rem_sh[RemW-1:0];
      d_nxt.root = {d_in.root[RootW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_nxt;
    end
  end
endmodule

// File: rtl/core/bdae_cordic_cell.sv
`timescale 1ns / 1ps
module bdae_cordic_cell #(
  parameter int Idx = 0
) (
  input  logic              clk,
  input  logic              en,
  input  bdae_pkg::cordic_t d_in,
  output bdae_pkg::cordic_t d_out
);
  import bdae_pkg::*;

  logic signed [CorW-1:0] xs;
  logic signed [CorW-1:0] ys;
  logic signed [AngW-1:0] ang;
  cordic_t                d_nxt;

  always_comb begin
    xs  = (d_in.x < 0) ? -((-d_in.x) >>> Idx) : (d_in.x >>> Idx);
    ys  = (d_in.y < 0) ? -((-d_in.y) >>> Idx) : (d_in.y >>> Idx);
    ang = $signed({2'b00, step_angle(Idx)});
    if (d_in.y >= 0) begin
      d_nxt.x = d_in.x + ys;
      d_nxt.y = d_in.y - xs;
      d_nxt.z = d_in.z + ang;
    end else begin
      d_nxt.x = d_in.x - ys;
      d_nxt.y = d_in.y + xs;
      d_nxt.z = d_in.z - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_nxt;
    end
  end
endmodule

// File: rtl/core/bdae_div_cell.sv
`timescale 1ns / 1ps
module bdae_div_cell (
  input  logic           clk,
  input  logic           en,
  input  bdae_pkg::div_t d_in,
  output bdae_pkg::div_t d_out
);
  import bdae_pkg::*;

  logic [DenW:0] rem_sh;
  div_t          d_nxt;

  always_comb begin
    rem_sh    = {d_in.rem, d_in.num[NumW-1]};
    d_nxt.den = d_in.den;
    d_nxt.num = {d_in.num[NumW-2:0], 1'b0};
    if (rem_sh >= {1'b0, d_in.den}) begin
      d_nxt.rem = DenW'(rem_sh - {1'b0, d_in.den});
      d_nxt.q   = {d_in.q[NumW-2:0], 1'b1};
    end else begin
      d_nxt.rem = rem_sh[DenW-1:0];
      d_nxt.q   = {d_in.q[NumW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_out <= d_nxt;
    end
  end
endmodule

// File: rtl/core/ball_distance_angle_estimator_top.sv
`timescale 1ns / 1ps
// Ball distance and aiming angle estimator.
// Input channel in_valid/in_ready/in_data carries one detected circle per item:
// centre column, centre row and radius in 1/16 pixel.
// Output channel out_valid/out_ready/out_data returns one result per item:
// distance in 1/16 cm, angle in 0.01 degree, side flag, band and zero flag.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes the eight
// row, pivot and centre registers; cfg_ready is always high, and an index
// beyond the list is dropped. Write registers only while the block is idle.
// Throughput is one item per cycle while the pipeline is not frozen. An
// accepted item passes 60 pipeline stages (input stage, square sum, 16 cells
// of square root and CORDIC side by side, three stages of reference
// diameters, span and divider setup, 39 restoring divider cells), and its
// result is then written into the output buffer, which drives out_valid.
// A two-entry output buffer holds results while the receiver stalls; the
// pipeline freezes and in_ready drops only when that buffer is full.
// Reset (rst_n low, synchronous) empties the pipeline and the buffer and
// loads the register defaults.
module ball_distance_angle_estimator_top (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  bdae_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output bdae_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [3:0]     cfg_index,
  input  logic [9:0]     cfg_data
);
  import bdae_pkg::*;

  localparam int NStages = 2 + CorSteps + 3 + NumW;

  typedef struct packed {
    logic [2:0]  band;
    logic        right;
    logic        vzero;
    logic        uzero;
    logic [11:0] rad;
  } front_sb_t;

  typedef struct packed {
    logic [2:0]  band;
    logic        right;
    logic        azero;
    logic [13:0] angle;
    logic        neg;
    logic        szero;
  } div_sb_t;

  logic [9:0] row1_r, row2_r, row3_r, row4_r, pvx_r, pvy_r, cx_r, cy_r;
  logic [NStages-1:0] vld_r;
  logic [1:0] cnt_r;
  out_t ent0_r, ent1_r;
  logic en, push, pop, in_acc;

  assign cfg_ready = 1'b1;
  assign en        = (cnt_r != 2'd2);
  assign in_ready  = en;
  assign in_acc    = in_valid && en;
  assign push      = en && vld_r[NStages-1];
  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  assign out_data  = ent0_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row1_r <= RST_ROW_ONE;
      row2_r <= RST_ROW_TWO;
      row3_r <= RST_ROW_THREE;
      row4_r <= RST_ROW_FOUR;
      pvx_r  <= RST_PIVOT_X;
      pvy_r  <= RST_PIVOT_Y;
      cx_r   <= RST_CENTRE_X;
      cy_r   <= RST_CENTRE_Y;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ROW_ONE:   row1_r <= cfg_data;
        REG_ROW_TWO:   row2_r <= cfg_data;
        REG_ROW_THREE: row3_r <= cfg_data;
        REG_ROW_FOUR:  row4_r <= cfg_data;
        REG_PIVOT_X:   pvx_r  <= cfg_data;
        REG_PIVOT_Y:   pvy_r  <= cfg_data;
        REG_CENTRE_X:  cx_r   <= cfg_data;
        REG_CENTRE_Y:  cy_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NStages-2:0], in_acc};
    end
  end

  // input stage
  logic signed [10:0] dx_nxt, dy_nxt, du_nxt, dv_nxt;
  logic signed [10:0] dx_r, dy_r;
  logic [9:0] u_nxt, v_nxt, u_r, v_r;
  front_sb_t sb0_nxt, sb0_r;

  always_comb begin
    if (in_data.pos_y >= row1_r) begin
      sb0_nxt.band = 3'd0;
    end else if (in_data.pos_y >= row2_r) begin
      sb0_nxt.band = 3'd1;
    end else if (in_data.pos_y >= row3_r) begin
      sb0_nxt.band = 3'd2;
    end else if (in_data.pos_y >= row4_r) begin
      sb0_nxt.band = 3'd3;
    end else begin
      sb0_nxt.band = 3'd4;
    end
    dx_nxt = $signed({1'b0, in_data.pos_x}) - $signed({1'b0, cx_r});
    dy_nxt = $signed({1'b0, in_data.pos_y}) - $signed({1'b0, cy_r});
    du_nxt = $signed({1'b0, pvx_r}) - $signed({1'b0, in_data.pos_x});
    dv_nxt = $signed({1'b0, pvy_r}) - $signed({1'b0, in_data.pos_y});
    u_nxt  = (du_nxt < 0) ? 10'(-du_nxt) : du_nxt[9:0];
    v_nxt  = (dv_nxt < 0) ? 10'(-dv_nxt) : dv_nxt[9:0];
    sb0_nxt.right = (in_data.pos_x > cx_r);
    sb0_nxt.vzero = (v_nxt == 10'd0);
    sb0_nxt.uzero = (u_nxt == 10'd0);
    sb0_nxt.rad   = in_data.radius_q4;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= dx_nxt;
      dy_r  <= dy_nxt;
      u_r   <= u_nxt;
      v_r   <= v_nxt;
      sb0_r <= sb0_nxt;
    end
  end

  // square sum and chain setup
  logic signed [21:0] sqx, sqy;
  logic [21:0] sqsum;
  sqrt_t   sq_c [0:CorSteps];
  cordic_t co_c [0:CorSteps];
  front_sb_t fsb_r [0:CorSteps];

  always_comb begin
    sqx   = dx_r * dx_r;
    sqy   = dy_r * dy_r;
    sqsum = 22'(sqx + sqy);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_c[0].rem  <= '0;
      sq_c[0].root <= '0;
      sq_c[0].op   <= {2'b00, sqsum, 8'h00};
      co_c[0].x    <= $signed({3'b000, v_r, 16'h0000});
      co_c[0].y    <= $signed({3'b000, u_r, 16'h0000});
      co_c[0].z    <= '0;
      fsb_r[0]     <= sb0_r;
    end
  end

  for (genvar k = 0; k < CorSteps; k++) begin : g_front
    bdae_sqrt_cell u_sqrt (
      .clk   (clk),
      .en    (en),
      .d_in  (sq_c[k]),
      .d_out (sq_c[k+1])
    );
    bdae_cordic_cell #(.Idx(k)) u_cordic (
      .clk   (clk),
      .en    (en),
      .d_in  (co_c[k]),
      .d_out (co_c[k+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        fsb_r[k+1] <= fsb_r[k];
      end
    end
  end

  // reference diameters and angle finish
  logic [28:0] dn_nxt, df_nxt, dn_r, df_r;
  logic signed [AngW-1:0] zc;
  logic [21:0] zcl;
  logic [13:0] ang_nxt, ang_r;
  front_sb_t sb18_r;
  front_sb_t fsb_end;

  always_comb begin
    fsb_end = fsb_r[CorSteps];
    dn_nxt = 29'(near_slope(fsb_end.band) * sq_c[CorSteps].root)
           + {2'b00, near_offset(fsb_end.band), 12'h000};
    df_nxt = 29'(far_slope(fsb_end.band) * sq_c[CorSteps].root)
           + {2'b00, far_offset(fsb_end.band), 12'h000};
    zc = co_c[CorSteps].z;
    if (zc < 0) begin
      zcl = '0;
    end else if (zc > 23'sd2304000) begin
      zcl = 22'd2304000;
    end else begin
      zcl = zc[21:0];
    end
    zcl = zcl + 22'd128;
    if (zcl[21:8] > 14'd9000) begin
      ang_nxt = 14'd9000;
    end else begin
      ang_nxt = zcl[21:8];
    end
    if (fsb_end.vzero) begin
      ang_nxt = fsb_end.uzero ? 14'd0 : 14'd9000;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dn_r   <= dn_nxt;
      df_r   <= df_nxt;
      ang_r  <= ang_nxt;
      sb18_r <= fsb_end;
    end
  end

  // span and numerator difference
  logic signed [31:0] diff_r;
  logic signed [29:0] span_r;
  logic [13:0] ang19_r;
  front_sb_t sb19_r;

  always_ff @(posedge clk) begin
    if (en) begin
      diff_r  <= $signed({3'b000, sb18_r.rad, 17'h00000}) - $signed({3'b000, dn_r});
      span_r  <= $signed({1'b0, df_r}) - $signed({1'b0, dn_r});
      ang19_r <= ang_r;
      sb19_r  <= sb18_r;
    end
  end

  // divider setup
  logic signed [41:0] num_s;
  logic [41:0] num_mag;
  logic [29:0] den_mag;
  div_t    dv_c [0:NumW];
  div_sb_t dsb_r [0:NumW];

  always_comb begin
    num_s   = diff_r * 42'sd800;
    num_mag = (num_s < 0) ? 42'(-num_s) : 42'(num_s);
    den_mag = (span_r < 0) ? 30'(-span_r) : 30'(span_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_c[0].rem    <= '0;
      dv_c[0].num    <= num_mag[NumW-1:0];
      dv_c[0].q      <= '0;
      dv_c[0].den    <= den_mag[DenW-1:0];
      dsb_r[0].band  <= sb19_r.band;
      dsb_r[0].right <= sb19_r.right;
      dsb_r[0].azero <= sb19_r.vzero;
      dsb_r[0].angle <= ang19_r;
      dsb_r[0].neg   <= (num_s < 0) ^ (span_r < 0);
      dsb_r[0].szero <= (span_r == 30'sd0);
    end
  end

  for (genvar j = 0; j < NumW; j++) begin : g_div
    bdae_div_cell u_div (
      .clk   (clk),
      .en    (en),
      .d_in  (dv_c[j]),
      .d_out (dv_c[j+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        dsb_r[j+1] <= dsb_r[j];
      end
    end
  end

  // result assembly
  logic signed [41:0] qs, dfull;
  div_sb_t dsb_end;
  out_t res;

  always_comb begin
    dsb_end = dsb_r[NumW];
    qs = $signed({3'b000, dv_c[NumW].q});
    if (dsb_end.neg) begin
      qs = -qs;
    end
    dfull = qs + $signed({29'd0, 13'(13'd800 + 13'd800 * dsb_end.band)});
    if (dsb_end.szero) begin
      res.distance_q4 = 16'sd0;
    end else if (dfull > 42'sd32767) begin
      res.distance_q4 = 16'sd32767;
    end else if (dfull < -42'sd32768) begin
      res.distance_q4 = -16'sd32768;
    end else begin
      res.distance_q4 = dfull[15:0];
    end
    res.angle_centideg = dsb_end.angle;
    res.right_side     = dsb_end.right;
    res.band_index     = dsb_end.band;
    res.zero_divisor   = dsb_end.szero | dsb_end.azero;
  end

  // output buffer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push && !pop) begin
      cnt_r <= cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        ent0_r <= res;
      end else begin
        ent0_r <= ent1_r;
        ent1_r <= res;
      end
    end else if (pop) begin
      ent0_r <= ent1_r;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        ent0_r <= res;
      end else begin
        ent1_r <= res;
      end
    end
  end
endmodule
